// ===== hw/rtl/slhd_pkg.sv =====
// Shared types, constants and the row mask function for the scrolling level
// history display unit. No dependencies.
package slhd_pkg;

  localparam int COLUMNS   = 16;
  localparam int ROWS      = 8;
  localparam int BANDS     = 7;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int FULL8     = 255;
  localparam int MIDLINE   = 127;
  localparam int ROW_PITCH = FULL8 / ROWS;
  localparam logic [13:0] PERIOD_RESET = 14'd125;
  localparam logic [13:0] ELAPSED_MAX  = 14'h3FFF;

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_TICK      = 2'd1,
    OP_BAND_DOWN = 2'd2,
    OP_BAND_UP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCALE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] peak;
    logic [15:0] full_scale;
  } scale_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } scale_rsp_t;

  // Centered bar: row j is lit when its center lies strictly within
  // half the value of the midline.
  function automatic logic [7:0] column_mask(input logic [7:0] value);
    logic [8:0] h;
    logic [8:0] c;
    logic [7:0] mask;
    h    = {2'b00, value[7:1]};
    mask = '0;
    if (h >= 9'(ROW_PITCH / 2)) begin
      for (int j = 0; j < ROWS; j++) begin
        c = 9'(j * ROW_PITCH + ROW_PITCH / 2);
        if ((c + h > 9'(MIDLINE)) && (c < 9'(MIDLINE) + h)) begin
          mask[j] = 1'b1;
        end
      end
    end
    return mask;
  endfunction

endpackage

// ===== hw/rtl/slhd_event_if.sv =====
// Input channel: valid/ready handshake carrying one event per transaction.
// Depends on slhd_pkg.
interface slhd_event_if;
  logic           valid;
  logic           ready;
  slhd_pkg::op_t  op;
  logic [3:0]     channel;
  logic [15:0]    level;
  logic [15:0]    full_scale;

  modport source(output valid, op, channel, level, full_scale, input ready);
  modport sink(input valid, op, channel, level, full_scale, output ready);
endinterface

// ===== hw/rtl/slhd_bar_if.sv =====
// Output channel: valid/ready handshake carrying one column mask per transaction.
// No dependencies.
interface slhd_bar_if;
  logic       valid;
  logic       ready;
  logic [5:0] column;
  logic [7:0] lit_rows;
  logic       last;

  modport source(output valid, column, lit_rows, last, input ready);
  modport sink(input valid, column, lit_rows, last, output ready);
endinterface

// ===== hw/rtl/slhd_scaler.sv =====
// Peak scaler: peak*255/full_scale with saturation, by restoring division
// one quotient bit per cycle. Depends on slhd_pkg.
module slhd_scaler (
  input  logic                    clk,
  input  logic                    rst,
  input  slhd_pkg::scale_req_t    req,
  output slhd_pkg::scale_rsp_t    rsp
);
  import slhd_pkg::*;

  logic        busy;
  logic        done;
  logic [2:0]  count;
  logic [15:0] rem;
  logic [7:0]  numer_lo;
  logic [15:0] den;
  logic [7:0]  quo;
  logic        sat;
  logic        zero;

  logic [23:0] numer;
  logic [16:0] trial;
  logic        fits;

  // peak*255 as (peak << 8) - peak. With peak <= full_scale the top 16 bits
  // are already below the divisor, so eight steps give the whole quotient.
  assign numer = {req.peak, 8'h00} - {8'h00, req.peak};
  assign trial = {rem, numer_lo[7]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
      end else if (busy && count == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      rem      <= numer[23:8];
      numer_lo <= numer[7:0];
      den      <= req.full_scale;
      count    <= 3'd7;
      quo      <= '0;
      zero     <= (req.full_scale == 16'd0) && (req.peak == 16'd0);
      sat      <= (req.peak > req.full_scale);
    end else if (busy) begin
      numer_lo <= {numer_lo[6:0], 1'b0};
      count    <= count - 3'd1;
      quo      <= {quo[6:0], fits};
      if (fits) begin
        rem <= 16'(trial - {1'b0, den});
      end else begin
        rem <= trial[15:0];
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (sat) begin
      rsp.value = 8'(FULL8);
    end else if (zero) begin
      rsp.value = 8'h00;
    end else begin
      rsp.value = quo;
    end
  end

endmodule

// ===== hw/rtl/scrolling_level_history_display_unit.sv =====
// Scrolling level history display unit: peak tracking, step timing, column
// history and the column sequencer. Depends on slhd_pkg, slhd_event_if,
// slhd_bar_if and slhd_scaler.
// A stepping tick moves the block from idle to the scale state for the
// division, then to the emit state, one column per cycle while the sink is
// ready; input ready returns as the last column is loaded into the output.
// Samples, band steps and ticks without a step leave the block idle and ready.
// The eight-step division in slhd_scaler sets the step latency.
// Synchronous active-high reset: period 125 ms, broadband, empty history.
module scrolling_level_history_display_unit (
  input  logic               clk,
  input  logic               rst,
  slhd_event_if.sink         events,
  slhd_bar_if.source         bars,
  input  logic               cfg_wr_en,
  input  logic [13:0]        cfg_wr_data
);
  import slhd_pkg::*;

  state_t           state;
  logic [13:0]      period;
  logic [13:0]      elapsed;
  logic [13:0]      elapsed_next;
  logic [15:0]      peak;
  logic [15:0]      latched_fs;
  logic [3:0]       band;
  logic [7:0]       hist [COLUMNS];
  logic [COL_W-1:0] col;
  logic             out_valid;
  logic [COL_W-1:0] out_col;
  logic [7:0]       out_mask;
  logic             out_last;

  logic             accept;
  logic             step;
  logic             slot_free;
  scale_req_t       req;
  scale_rsp_t       rsp;

  assign accept       = events.valid && events.ready;
  assign events.ready = (state == ST_IDLE);
  assign elapsed_next = (elapsed < ELAPSED_MAX) ? elapsed + 14'd1 : elapsed;
  assign step         = accept && (events.op == OP_TICK) && (elapsed_next >= period);
  assign slot_free    = !out_valid || bars.ready;

  assign req.start      = step;
  assign req.peak       = peak;
  assign req.full_scale = latched_fs;

  slhd_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      elapsed    <= '0;
      peak       <= '0;
      latched_fs <= '0;
      band       <= 4'(BANDS);
      col        <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < COLUMNS; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (bars.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (events.op)
              OP_SAMPLE: begin
                if (events.channel == band) begin
                  latched_fs <= events.full_scale;
                  if (events.level > peak) begin
                    peak <= events.level;
                  end
                end
              end
              OP_BAND_DOWN: begin
                if (band != 4'd0) begin
                  band <= band - 4'd1;
                end
              end
              OP_BAND_UP: begin
                if (band < 4'(BANDS)) begin
                  band <= band + 4'd1;
                end
              end
              OP_TICK: begin
                if (step) begin
                  elapsed <= '0;
                  state   <= ST_SCALE;
                end else begin
                  elapsed <= elapsed_next;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCALE: begin
          if (rsp.done) begin
            for (int i = COLUMNS - 1; i > 0; i--) begin
              hist[i] <= hist[i-1];
            end
            hist[0] <= rsp.value;
            peak    <= '0;
            col     <= '0;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // One column per transaction; the output register frees the input
          // side as soon as the last column is loaded.
          if (slot_free) begin
            if (col == COL_W'(COLUMNS - 1)) begin
              state <= ST_IDLE;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      out_col  <= col;
      out_mask <= column_mask(hist[col]);
      out_last <= (col == COL_W'(COLUMNS - 1));
    end
  end

  assign bars.valid    = out_valid;
  assign bars.column   = 6'(out_col);
  assign bars.lit_rows = out_mask;
  assign bars.last     = out_last;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the scrolling level history display unit.
// Drives level, tick and band events, predicts every column mask in a small
// scoreboard class. Depends on slhd_pkg, both interfaces and the unit.
module testbench;
  import slhd_pkg::*;

  typedef struct {
    logic [5:0] column;
    logic [7:0] rows;
    logic       last;
  } bar_t;

  class bar_scoreboard;
    logic [13:0] period;
    logic [15:0] peak;
    logic [15:0] full_scale;
    logic [13:0] elapsed;
    logic [7:0]  history [COLUMNS];
    logic [3:0]  band;
    bar_t        pending_bars [$];
    int          errors;
    int          steps;
    int          bars_checked;

    function new();
      period     = PERIOD_RESET;
      peak       = '0;
      full_scale = '0;
      elapsed    = '0;
      band       = 4'(BANDS);
      errors     = 0;
      steps      = 0;
      bars_checked = 0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void set_period(logic [13:0] value);
      period = value;
    endfunction

    // Updates the shadow state for one accepted event and queues the column
    // masks of a frame when the tick completes a step.
    function void note_event(op_t op, logic [3:0] ch, logic [15:0] lvl,
                             logic [15:0] fs);
      int unsigned scaled;
      int unsigned h;
      int unsigned c;
      bar_t        b;
      case (op)
        OP_SAMPLE: begin
          if (ch == band) begin
            full_scale = fs;
            if (lvl > peak) peak = lvl;
          end
        end
        OP_BAND_DOWN: begin
          if (band > 0) band--;
        end
        OP_BAND_UP: begin
          if (band < BANDS) band++;
        end
        default: begin
          if (elapsed < ELAPSED_MAX) elapsed++;
          if (elapsed >= period) begin
            elapsed = '0;
            if (full_scale == 0) scaled = (peak != 0) ? FULL8 : 0;
            else if (peak > full_scale) scaled = FULL8;
            else scaled = (32'(peak) * FULL8) / 32'(full_scale);
            for (int i = COLUMNS - 1; i > 0; i--) history[i] = history[i - 1];
            history[0] = 8'(scaled);
            peak = '0;
            steps++;
            for (int i = 0; i < COLUMNS; i++) begin
              h = history[i] / 2;
              b.rows = '0;
              if (h >= ROW_PITCH / 2) begin
                for (int j = 0; j < ROWS; j++) begin
                  c = j * ROW_PITCH + ROW_PITCH / 2;
                  if (c + h > MIDLINE && c < MIDLINE + h) b.rows[j] = 1'b1;
                end
              end
              b.column = 6'(i);
              b.last   = (i == COLUMNS - 1);
              pending_bars.push_back(b);
            end
          end
        end
      endcase
    endfunction

    function void check_bar(logic [5:0] column, logic [7:0] rows, logic last);
      bar_t b;
      if (pending_bars.size() == 0) begin
        $error("unexpected column mask: column %0d lit_rows %h last %0d",
               column, rows, last);
        errors++;
        return;
      end
      b = pending_bars.pop_front();
      bars_checked++;
      if (column !== b.column) begin
        $error("column: expected %0d, actual %0d", b.column, column);
        errors++;
      end
      if (rows !== b.rows) begin
        $error("lit_rows: expected %h, actual %h", b.rows, rows);
        errors++;
      end
      if (last !== b.last) begin
        $error("last: expected %0d, actual %0d", b.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bars.size();
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;

  logic          clk;
  logic          rst;
  logic          cfg_wr_en;
  logic [13:0]   cfg_wr_data;
  slhd_event_if  ev ();
  slhd_bar_if    br ();
  bar_scoreboard sb;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int idle_cycles;
  int sent_items;

  scrolling_level_history_display_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .events      (ev),
    .bars        (br),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Output side: ready changes at the falling edge, a long hold-off counts
  // down here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      br.ready = 1'b0;
      hold_left--;
    end else begin
      br.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && br.valid && br.ready) begin
      sb.check_bar(br.column, br.lit_rows, br.last);
    end
    if (!rst && ((br.valid && br.ready) || (ev.valid && ev.ready))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic offer_event(op_t op, logic [3:0] ch, logic [15:0] lvl,
                             logic [15:0] fs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      ev.valid = 1'b0;
      @(negedge clk);
    end
    ev.valid      = 1'b1;
    ev.op         = op;
    ev.channel    = ch;
    ev.level      = lvl;
    ev.full_scale = fs;
    do @(posedge clk); while (!ev.ready);
    sb.note_event(op, ch, lvl, fs);
    sent_items++;
  endtask

  // Drops valid, waits for every queued mask and lets a possible step in
  // flight finish.
  task automatic wait_idle();
    @(negedge clk);
    ev.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [13:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    sb.set_period(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly samples on the selected band and ticks, with some noise on other
  // channels and band steps that move the selection around.
  task automatic send_random_events(int count);
    int          r;
    op_t         op;
    logic [3:0]  ch;
    logic [15:0] lvl;
    logic [15:0] fs;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45) op = OP_SAMPLE;
      else if (r < 85) op = OP_TICK;
      else if (r < 92) op = OP_BAND_DOWN;
      else op = OP_BAND_UP;
      ch = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : sb.band;
      case ($urandom_range(7))
        0: lvl = 16'd0;
        1: lvl = 16'hFFFF;
        2: lvl = 16'($urandom_range(255));
        default: lvl = 16'($urandom_range(65535));
      endcase
      case ($urandom_range(5))
        0: fs = 16'd0;
        1: fs = 16'hFFFF;
        2: fs = (lvl > 16'hFF00) ? 16'hFFFF : lvl + 16'($urandom_range(255));
        default: fs = 16'($urandom_range(65535));
      endcase
      offer_event(op, ch, lvl, fs);
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    ev.valid      = 1'b0;
    ev.op         = OP_SAMPLE;
    ev.channel    = '0;
    ev.level      = '0;
    ev.full_scale = '0;
    br.ready      = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 66;
    hold_left     = 0;
    idle_cycles   = 0;
    sent_items    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The reset period of 125 ms gives no step within a few ticks.
    offer_event(OP_SAMPLE, 4'(BANDS), 16'd1000, 16'd4000);
    repeat (4) offer_event(OP_TICK, '0, '0, '0);

    // Period zero steps on every tick.
    write_period(14'd0);
    offer_event(OP_TICK, '0, '0, '0);
    offer_event(OP_SAMPLE, 4'(BANDS), 16'hFFFF, 16'd0);
    offer_event(OP_TICK, '0, '0, '0);
    offer_event(OP_SAMPLE, 4'(BANDS), 16'd0, 16'd0);
    offer_event(OP_TICK, '0, '0, '0);
    offer_event(OP_SAMPLE, 4'(BANDS), 16'hFFFF, 16'hFFFF);
    offer_event(OP_TICK, '0, '0, '0);
    offer_event(OP_SAMPLE, 4'(BANDS), 16'd40000, 16'd1000);
    offer_event(OP_TICK, '0, '0, '0);
    offer_event(OP_SAMPLE, 4'd3, 16'd500, 16'd1000);
    offer_event(OP_SAMPLE, 4'(BANDS), 16'd100, 16'd1000);
    offer_event(OP_SAMPLE, 4'(BANDS), 16'd50, 16'd1000);
    offer_event(OP_TICK, '0, '0, '0);
    // Band up at broadband and band down at zero are both ignored.
    offer_event(OP_BAND_UP, '0, '0, '0);
    repeat (8) offer_event(OP_BAND_DOWN, '0, '0, '0);
    offer_event(OP_SAMPLE, 4'd0, 16'd1, 16'hFFFF);
    offer_event(OP_SAMPLE, 4'hF, 16'hFFFF, 16'd1);
    offer_event(OP_TICK, '0, '0, '0);
    offer_event(OP_BAND_UP, '0, '0, '0);

    send_idle_pct = 7;
    recv_idle_pct = 66;
    write_period(14'd1);
    send_random_events(25);
    write_period(14'($urandom_range(6, 2)));
    send_random_events(25);

    send_idle_pct = 66;
    recv_idle_pct = 7;
    write_period(14'($urandom_range(5, 1)));
    send_random_events(45);

    // The sink holds off while ticks keep coming, so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_period(14'd1);
    hold_left = 400;
    send_random_events(45);

    // The longest period gives no step within a few ticks.
    write_period(14'h3FFF);
    offer_event(OP_SAMPLE, sb.band, 16'd30000, 16'd60000);
    repeat (3) offer_event(OP_TICK, '0, '0, '0);

    wait_idle();
    $display("Sent %0d events over periods 0, 1, 125, 16383 and random ones;",
             sent_items);
    $display("checked %0d column masks from %0d history steps.",
             sb.bars_checked, sb.steps);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
